// ===== hw/rtl/dkenc_pkg.sv =====
// Shared constants, widths and inter-stage word types for the decimal128 key encoder.
// No dependencies; every other file imports this package.
package dkenc_pkg;

  localparam int DIGIT_COUNT = 34;
  localparam int EXP_BIAS    = 6176;
  localparam int IN_DIGITS   = 34;
  localparam int MAX_KEY     = 17;

  localparam int DIG_W    = 4 * DIGIT_COUNT;
  localparam int CNT_W    = $clog2(DIGIT_COUNT + 1);
  localparam int GROUPS   = (DIGIT_COUNT + 2) / 3;
  localparam int GRP_W    = $clog2(GROUPS + 1);
  localparam int PAD_W    = 12 * GROUPS;
  localparam int EXP_W    = 16;
  localparam int KEY_BITS = EXP_W + 10 * GROUPS;
  localparam int KEY_BYTES = (KEY_BITS + 7) / 8;
  localparam int KEY_W    = 8 * KEY_BYTES;
  localparam int BPOS_W   = $clog2(KEY_BITS + 1);
  localparam int LEN_W    = 5;

  localparam logic [EXP_W-1:0] BIAS_ONE   = EXP_W'(EXP_BIAS + 1);
  localparam logic [EXP_W-1:0] EXP_OFFSET = EXP_W'(2 * (EXP_BIAS + 1));

  // Normalized coefficient, digit 0 in the top nibble.
  typedef struct packed {
    logic             sign;
    logic [CNT_W-1:0] dig;
    logic [EXP_W-1:0] ef;
    logic [DIG_W-1:0] coeff;
  } norm_t;

  // Fully packed key, byte 0 in the top byte.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } key_t;

endpackage

// ===== hw/rtl/decimal128_index_key_encoder_unit.sv =====
// Top level of the decimal128 index key encoder: normalizer, packer and byte serializer.
// Depends on dkenc_pkg, dkenc_norm, dkenc_pack and dkenc_ser.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in_     | input     | in_valid / in_stall  | sign, exponent, digits_high/mid/low (34 BCD)
//  out_    | output    | out_valid / out_stall| key_byte, byte_index, last (one key byte)
//
// Each value leaves as many bytes as its key has (2 to 17), one per output word from
// the byte-wide serializer at the end, which takes the next key only with the final
// byte; the four stages ahead of it accept a new word every cycle unless stalled. A
// word passes two normalizer and two packer registers before its first byte shows.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
// A stall on out_ holds the current byte and backs up stage by stage to in_stall.
module decimal128_index_key_encoder_unit import dkenc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_sign,
  input  logic signed [13:0] in_exponent,
  input  logic [63:0]        in_digits_high,
  input  logic [63:0]        in_digits_mid,
  input  logic [7:0]         in_digits_low,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_key_byte,
  output logic [4:0]         out_byte_index,
  output logic               out_last
);

  // normalizer -> packer
  logic  norm_valid;
  logic  norm_stall;
  norm_t norm_word;

  // packer -> serializer
  logic  key_valid;
  logic  key_stall;
  key_t  key_word;

  // strip leading zeros, find digit count, build exponent field
  dkenc_norm u_norm (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sign        (in_sign),
    .in_exponent    (in_exponent),
    .in_digits_high (in_digits_high),
    .in_digits_mid  (in_digits_mid),
    .in_digits_low  (in_digits_low),
    .out_valid      (norm_valid),
    .out_stall      (norm_stall),
    .out_word       (norm_word)
  );

  // complement negatives, pack 10-bit groups, size the key
  dkenc_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (norm_valid),
    .in_stall  (norm_stall),
    .in_word   (norm_word),
    .out_valid (key_valid),
    .out_stall (key_stall),
    .out_word  (key_word)
  );

  // shift the key out one byte per word; load the next key on the final byte
  dkenc_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (key_valid),
    .in_stall       (key_stall),
    .in_word        (key_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_byte   (out_key_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

endmodule

// ===== hw/rtl/dkenc_norm.sv =====
// Front end: leading/trailing zero search, coefficient shift and exponent field.
// Two register stages; depends on dkenc_pkg.
module dkenc_norm import dkenc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_sign,
  input  logic signed [13:0]       in_exponent,
  input  logic [63:0]              in_digits_high,
  input  logic [63:0]              in_digits_mid,
  input  logic [7:0]               in_digits_low,
  output logic                     out_valid,
  input  logic                     out_stall,
  output norm_t                    out_word
);

  logic [4*IN_DIGITS-1:0] all_digits;
  logic [DIG_W-1:0]       coeff;
  logic [CNT_W-1:0]       first;
  logic [CNT_W-1:0]       lastnz;
  logic                   any_nz;

  logic                   a_v_r;
  logic                   a_sign_r;
  logic [13:0]            a_exp_r;
  logic [DIG_W-1:0]       a_coeff_r;
  logic [CNT_W-1:0]       a_first_r;
  logic [CNT_W-1:0]       a_lastnz_r;
  logic                   a_any_r;

  logic                   b_v_r;
  norm_t                  b_word_r;
  norm_t                  b_word_nxt;
  logic                   a_ready;
  logic                   b_ready;
  logic [EXP_W-1:0]       x;

  assign all_digits = {in_digits_high, in_digits_mid, in_digits_low};
  assign coeff      = all_digits[DIG_W-1:0];

  assign b_ready  = !b_v_r || !out_stall;
  assign a_ready  = !a_v_r || b_ready;
  assign in_stall = !a_ready;

  // priority search for the first and last nonzero digit
  always_comb begin
    first  = CNT_W'(DIGIT_COUNT);
    lastnz = '0;
    any_nz = 1'b0;
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      if (coeff[4*(DIGIT_COUNT-1-i) +: 4] != 4'd0) first = CNT_W'(i);
    end
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (coeff[4*(DIGIT_COUNT-1-i) +: 4] != 4'd0) begin
        lastnz = CNT_W'(i);
        any_nz = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_sign_r   <= in_sign;
      a_exp_r    <= in_exponent;
      a_coeff_r  <= coeff;
      a_first_r  <= first;
      a_lastnz_r <= lastnz;
      a_any_r    <= any_nz;
    end
  end

  // shift out leading zeros, lower the exponent by their count, bias and sign it, count digits
  always_comb begin
    x = {{(EXP_W-14){a_exp_r[13]}}, a_exp_r} - EXP_W'(a_first_r) + BIAS_ONE;
    if (!a_any_r) x = '0;
    if (a_sign_r) x = -x;
    b_word_nxt.sign  = a_sign_r;
    b_word_nxt.dig   = a_any_r ? (a_lastnz_r - a_first_r + CNT_W'(1)) : '0;
    b_word_nxt.ef    = x + EXP_OFFSET;
    b_word_nxt.coeff = a_coeff_r << {a_first_r, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
    if (b_ready && a_v_r) begin
      b_word_r <= b_word_nxt;
    end
  end

  assign out_valid = b_v_r;
  assign out_word  = b_word_r;

endmodule

// ===== hw/rtl/dkenc_pack.sv =====
// Back end: nine complement for negatives, three-digit grouping and key length.
// Two register stages; depends on dkenc_pkg.
module dkenc_pack import dkenc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  norm_t in_word,
  output logic  out_valid,
  input  logic  out_stall,
  output key_t  out_word
);

  logic              c_v_r;
  norm_t             c_word_r;
  norm_t             c_word_nxt;
  logic              d_v_r;
  key_t              d_word_r;
  key_t              d_word_nxt;
  logic              c_ready;
  logic              d_ready;

  logic [3:0]        dg;
  logic [PAD_W-1:0]  pad;
  logic [10:0]       gsum;
  logic [KEY_W-1:0]  key_v;
  logic [GRP_W-1:0]  ng;
  logic [BPOS_W-1:0] bitpos;
  logic [LEN_W-1:0]  nbytes;
  logic [7:0]        pbyte;
  logic [LEN_W-1:0]  len;

  assign d_ready  = !d_v_r || !out_stall;
  assign c_ready  = !c_v_r || d_ready;
  assign in_stall = !c_ready;

  // for negatives, decrement the last significant digit, then nine-complement the significant digits
  always_comb begin
    c_word_nxt = in_word;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      dg = in_word.coeff[4*(DIGIT_COUNT-1-i) +: 4];
      if (in_word.sign && (int'(in_word.dig) > i)) begin
        if (int'(in_word.dig) == i + 1) dg = dg - 4'd1;
        dg = 4'd9 - dg;
      end
      c_word_nxt.coeff[4*(DIGIT_COUNT-1-i) +: 4] = dg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_ready) begin
      c_v_r <= in_valid;
    end
    if (c_ready && in_valid) begin
      c_word_r <= c_word_nxt;
    end
  end

  // pack groups of three digits into 10-bit fields behind the exponent
  always_comb begin
    pad = '0;
    pad[PAD_W-1 -: DIG_W] = c_word_r.coeff;
    key_v = '0;
    key_v[KEY_W-1 -: EXP_W] = c_word_r.ef;
    ng = '0;
    for (int g = 0; g < GROUPS; g++) begin
      gsum = 11'(pad[PAD_W-1-12*g -: 4]) * 11'd100
           + 11'(pad[PAD_W-5-12*g -: 4]) * 11'd10
           + 11'(pad[PAD_W-9-12*g -: 4]);
      key_v[KEY_W-1-EXP_W-10*g -: 10] = gsum[9:0];
      if (int'(c_word_r.dig) > 3 * g) ng = GRP_W'(g + 1);
    end
    bitpos = BPOS_W'(EXP_W) + BPOS_W'(ng) * BPOS_W'(10);
    nbytes = LEN_W'(bitpos >> 3);
    pbyte  = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (nbytes == LEN_W'(b)) pbyte = key_v[KEY_W-1-8*b -: 8];
    end
    // emit a trailing partial byte only when it carries a one
    len = nbytes;
    if ((bitpos[2:0] != 3'd0) && (pbyte != 8'd0)) len = nbytes + LEN_W'(1);
    if (int'(len) > MAX_KEY) len = LEN_W'(MAX_KEY);
    d_word_nxt.key = key_v;
    d_word_nxt.len = len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (d_ready) begin
      d_v_r <= c_v_r;
    end
    if (d_ready && c_v_r) begin
      d_word_r <= d_word_nxt;
    end
  end

  assign out_valid = d_v_r;
  assign out_word  = d_word_r;

endmodule

// ===== hw/rtl/dkenc_ser.sv =====
// Byte serializer: shifts a packed key out one byte per accepted word.
// Depends on dkenc_pkg.
module dkenc_ser import dkenc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  key_t             in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_key_byte,
  output logic [LEN_W-1:0] out_byte_index,
  output logic             out_last
);

  logic             v_r;
  logic [KEY_W-1:0] key_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] idx_r;
  logic             last_w;
  logic             take;

  assign last_w   = (idx_r + LEN_W'(1)) == len_r;
  assign take     = !v_r || (!out_stall && last_w);
  assign in_stall = !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (take) begin
      v_r <= in_valid;
    end
    if (take && in_valid) begin
      key_r <= in_word.key;
      len_r <= in_word.len;
      idx_r <= '0;
    end else if (v_r && !out_stall) begin
      key_r <= key_r << 8;
      idx_r <= idx_r + LEN_W'(1);
    end
  end

  assign out_valid      = v_r;
  assign out_key_byte   = key_r[KEY_W-1 -: 8];
  assign out_byte_index = idx_r;
  assign out_last       = last_w;

  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> (len_r >= LEN_W'(2)) && (idx_r < len_r))
    else $error("serializer index outside key length");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !out_stall && !last_w |=> v_r && (idx_r == $past(idx_r) + LEN_W'(1)))
    else $error("serializer did not advance to next byte");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !out_stall && last_w && !in_valid |=> !v_r)
    else $error("serializer kept valid after final byte");

endmodule
